@@ src/minv_pkg.sv @@
// Shared types, constants and cofactor term table for the 4x4 inverter.
package minv_pkg;
	localparam int N_ELEM = 16;
	localparam int N_TERM = 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAIR,
		ST_TERM,
		ST_DET,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
	} triple_t;

	// Return the factor indices of term t of cofactor i.
	function automatic triple_t term_lookup(input logic [3:0] i, input logic [2:0] t);
		logic [1:0] r;
		logic [1:0] c;
		logic [3:0] rows [3];
		logic [3:0] cols [3];
		logic [1:0] n;
		triple_t tr;
		r = i[3:2];
		c = i[1:0];
		n = 2'd0;
		rows[0] = 4'd0; rows[1] = 4'd0; rows[2] = 4'd0;
		cols[0] = 4'd0; cols[1] = 4'd0; cols[2] = 4'd0;
		// cofactor (r,c) uses rows != c and columns != r (transposed)
		for (int k = 0; k < 4; k++) begin
			if (k[1:0] != c) begin
				rows[n] = 4'(k * 4);
				n = n + 2'd1;
			end
		end
		n = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (k[1:0] != r) begin
				cols[n] = 4'(k);
				n = n + 2'd1;
			end
		end
		// pattern: a row t/2 col 0 ; b,c remaining rows with cols 1,2
		case (t)
			3'd0: tr = '{rows[0] + cols[0], rows[1] + cols[1], rows[2] + cols[2]};
			3'd1: tr = '{rows[0] + cols[0], rows[1] + cols[2], rows[2] + cols[1]};
			3'd2: tr = '{rows[1] + cols[0], rows[0] + cols[1], rows[2] + cols[2]};
			3'd3: tr = '{rows[1] + cols[0], rows[0] + cols[2], rows[2] + cols[1]};
			3'd4: tr = '{rows[2] + cols[0], rows[0] + cols[1], rows[1] + cols[2]};
			default: tr = '{rows[2] + cols[0], rows[0] + cols[2], rows[1] + cols[1]};
		endcase
		return tr;
	endfunction
endpackage

@@ src/minv_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module minv_div import minv_pkg::*; #(
	parameter int NW = 96,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;

	assign sh   = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// flag the cycle after the last step, once quo_q is final
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

@@ src/matrix_inverse_4x4.sv @@
// Top level: 4x4 fixed-point matrix inverse by cofactors and adjugate.
// Load sixteen elements in row-major order (s_tvalid/s_tready). After the
// last one the block runs one shared multiplier through 192 products for the
// cofactors (6 terms x 2 products x 16 cofactors, one product per cycle) and
// 4 more for the determinant, then for each of the 16 results one bit-serial
// divide of DN steps (69 at W=32, F=16), whose result is saturated, registered
// and output. s_tready is low from the sixteenth element until the last result
// is taken. Singular matrices skip the divide and give sixteen zeros with
// singular set; overflow saturates.
module matrix_inverse_4x4 import minv_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // elem_value[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // inv_value[31:0]
	output logic        m_tuser,   // singular
	output logic        m_tlast    // last_out
);
	localparam int W  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int NW = W + F;
	localparam int SW = PW + 4;
	localparam int DN = ((NW > SW) ? NW : SW) + 1;

	localparam logic signed [PW-1:0] SAT_HI = PW'((64'd1 << (W - 1)) - 64'd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);
	localparam logic signed [PW-1:0] HALF   = PW'(64'd1 << (F - 1));

	state_t state_q, state_d;
	logic [3:0]   ld_q;
	logic [3:0]   idx_q;
	logic [2:0]   t_q;
	logic [1:0]   k_q;
	logic signed [W-1:0]  mat_q [N_ELEM];
	logic signed [W-1:0]  cof_q [N_ELEM];
	logic signed [W-1:0]  pair_q;
	logic signed [SW-1:0] acc_q;
	logic signed [SW-1:0] det_q;
	logic         sing_q;
	logic signed [W-1:0]  res_q;
	logic         ovalid_q;
	logic         olast_q;
	logic         div_busy_q;

	triple_t tr;
	logic signed [W-1:0]  ma, mb;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd;
	logic signed [W-1:0]  rnd_sat;
	logic signed [SW-1:0] acc_nx;
	logic signed [SW-1:0] cof_fin;
	logic signed [W-1:0]  cof_sat;
	logic         div_start, div_done;
	logic [NW-1:0] div_num;
	logic [SW-1:0] det_mag;
	logic signed [W-1:0] cur_cof;
	logic [W-1:0]  cof_mag;
	logic         neg;
	logic [DN-1:0] num_r;
	logic [DN-1:0] div_quo_w;
	logic signed [DN:0] q_s;

	assign tr = term_lookup(idx_q, t_q);

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_PAIR: begin ma = mat_q[tr.a]; mb = mat_q[tr.b]; end
			ST_TERM: begin ma = pair_q;      mb = mat_q[tr.c]; end
			default: begin ma = mat_q[{k_q, 2'b00} >> 2]; mb = cof_q[{k_q, 2'b00}]; end
		endcase
	end

	assign prod = ma * mb;
	assign rnd  = (prod + HALF) >>> F;
	assign rnd_sat = (rnd > SAT_HI) ? SAT_HI[W-1:0] :
	                 (rnd < SAT_LO) ? SAT_LO[W-1:0] : rnd[W-1:0];

	// term signs follow + - - + + -
	always_comb begin
		case (t_q)
			3'd0, 3'd3, 3'd4: acc_nx = acc_q + SW'(rnd);
			default:          acc_nx = acc_q - SW'(rnd);
		endcase
	end

	assign cof_fin = (idx_q[2] ^ idx_q[0]) ? -acc_nx : acc_nx;
	assign cof_sat = (cof_fin > SW'(SAT_HI)) ? SAT_HI[W-1:0] :
	                 (cof_fin < SW'(SAT_LO)) ? SAT_LO[W-1:0] : cof_fin[W-1:0];

	assign cur_cof  = cof_q[idx_q];
	assign cof_mag  = cur_cof[W-1] ? -cur_cof : cur_cof;
	assign det_mag  = det_q[SW-1] ? -det_q : det_q;
	assign neg      = cur_cof[W-1] ^ det_q[SW-1];
	assign div_num  = {cof_mag, {F{1'b0}}};
	assign div_start = (state_q == ST_DIV) && !ovalid_q && !div_busy_q && !sing_q;

	// round to nearest: add half the divisor before dividing
	assign num_r = DN'(div_num) + DN'(det_mag >> 1);

	minv_div #(.NW(DN), .DW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_r), .den(det_mag), .done(div_done), .quo(div_quo_w)
	);
	assign q_s = neg ? -{1'b0, div_quo_w} : {1'b0, div_quo_w};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (s_tvalid && ld_q == 4'd15) state_d = ST_PAIR;
			ST_PAIR: state_d = ST_TERM;
			ST_TERM: if (t_q == 3'd5 && idx_q == 4'd15) state_d = ST_DET;
			         else state_d = ST_PAIR;
			ST_DET:  if (k_q == 2'd3) state_d = ST_DIV;
			ST_DIV:  if (div_done || (sing_q && !ovalid_q)) state_d = ST_OUT;
			ST_OUT:  if (m_tready) state_d = (idx_q == 4'd15) ? ST_LOAD : ST_DIV;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			ld_q       <= '0;
			idx_q      <= '0;
			t_q        <= '0;
			k_q        <= '0;
			ovalid_q   <= 1'b0;
			div_busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_tvalid && s_tready) ld_q <= ld_q + 4'd1;
			if (state_q == ST_TERM) begin
				t_q <= (t_q == 3'd5) ? 3'd0 : t_q + 3'd1;
				if (t_q == 3'd5) idx_q <= idx_q + 4'd1;
			end
			if (state_q == ST_DET) k_q <= k_q + 2'd1;
			if (div_start) div_busy_q <= 1'b1;
			if (div_done) div_busy_q <= 1'b0;
			if (state_q == ST_DIV && state_d == ST_OUT) ovalid_q <= 1'b1;
			if (state_q == ST_OUT && m_tready) begin
				ovalid_q <= 1'b0;
				idx_q    <= idx_q + 4'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) mat_q[ld_q] <= s_tdata[W-1:0];
		if (state_q == ST_PAIR) begin
			pair_q <= rnd_sat;
			if (t_q == 3'd0) acc_q <= '0;
		end
		if (state_q == ST_TERM) begin
			acc_q <= acc_nx;
			if (t_q == 3'd5) cof_q[idx_q] <= cof_sat;
		end
		if (state_q == ST_TERM && t_q == 3'd5 && idx_q == 4'd15) det_q <= '0;
		if (state_q == ST_DET) begin
			det_q  <= det_q + SW'(rnd);
			sing_q <= (det_q + SW'(rnd)) == '0;
		end
		if (state_q == ST_DIV && state_d == ST_OUT) begin
			if (sing_q) res_q <= '0;
			else if (q_s > (DN+1)'(SAT_HI)) res_q <= SAT_HI[W-1:0];
			else if (q_s < (DN+1)'(SAT_LO)) res_q <= SAT_LO[W-1:0];
			else res_q <= q_s[W-1:0];
			olast_q <= idx_q == 4'd15;
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = 32'(res_q);
	assign m_tuser  = sing_q;
	assign m_tlast  = olast_q;
endmodule

@@ src/minv_chk.sv @@
// Port-level checker for the 4x4 inverter, bound to the top level.
module minv_chk (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata,
	input logic m_tuser,
	input logic m_tlast
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output overlap");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0) else $error("singular nonzero");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready) else $error("no reload");
endmodule

bind matrix_inverse_4x4 minv_chk u_chk (.*);
